// ===== src/gsb_pkg.sv =====
// gsb_pkg: widths, register map and fixed-point constants for the Gaussian spot brightener.
// Standalone; the pixel interfaces and the core import it.
package gsb_pkg;

  // Pixel payload
  localparam int unsigned CHAN_W  = 8;
  localparam int unsigned NCHAN   = 3;
  localparam int unsigned COORD_W = 10;
  localparam int unsigned CHAN_MAX = 255;

  // Configuration registers
  localparam int unsigned CROW_W    = 11;
  localparam int unsigned CCOL_W    = 12;
  localparam int unsigned FALL_W    = 32;
  localparam int unsigned PDATA_W   = 32;
  localparam int unsigned PADDR_W   = 4;
  localparam int unsigned REG_IDX_W = 2;

  localparam logic [REG_IDX_W-1:0] REG_CENTRE_ROW = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_CENTRE_COL = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_FALLOFF    = 2'd2;

  // Geometry
  localparam int unsigned MAX_DIM           = 1024;
  localparam int unsigned EXP_FRAC_BITS_DEF = 16;
  localparam int unsigned DIFF_W = 13;               // signed coordinate difference
  localparam int unsigned SQ_W   = 24;               // one squared difference
  localparam int unsigned D2_W   = 25;               // squared distance
  localparam int unsigned X_W    = D2_W + FALL_W;    // exponent argument, Q.24

  // Range reduction x = n*ln2 + r
  localparam int unsigned LN2_Q24 = 32'hB17218;
  localparam int unsigned LN2_W   = 24;
  localparam int unsigned FAR_N   = 40;
  localparam logic [X_W-1:0] FAR_X = X_W'(64'(FAR_N + 1) * 64'(LN2_Q24));
  localparam int unsigned XR_W      = 29;            // x below FAR_X fits here
  localparam int unsigned N_W       = 6;
  localparam int unsigned RCP_SHIFT = 40;
  localparam int unsigned RCP_W     = 17;
  localparam logic [RCP_W-1:0] RCP_LN2 =
    RCP_W'((64'd1 << RCP_SHIFT) / 64'(LN2_Q24));

  // Taylor series in Q.30
  localparam int unsigned Q_FRAC  = 30;
  localparam int unsigned T_W     = 30;
  localparam int unsigned E_ACC_W = 32;
  localparam logic [T_W-1:0] LN2_Q30 = T_W'(64'(LN2_Q24) << (T_W - LN2_W));
  localparam int unsigned TAYLOR_TERMS = 12;
  localparam int unsigned DIV_SHIFT    = 34;
  localparam int unsigned DIV_RCP_W    = 34;

  // ceil(2^34 / k): exact floor division by k for any 30-bit dividend
  localparam logic [DIV_RCP_W-1:0] DIV_RCP [0:TAYLOR_TERMS] = '{
    DIV_RCP_W'(0),
    DIV_RCP_W'(0),
    DIV_RCP_W'(((64'd1 << DIV_SHIFT) + 64'd1)  / 64'd2),
    DIV_RCP_W'(((64'd1 << DIV_SHIFT) + 64'd2)  / 64'd3),
    DIV_RCP_W'(((64'd1 << DIV_SHIFT) + 64'd3)  / 64'd4),
    DIV_RCP_W'(((64'd1 << DIV_SHIFT) + 64'd4)  / 64'd5),
    DIV_RCP_W'(((64'd1 << DIV_SHIFT) + 64'd5)  / 64'd6),
    DIV_RCP_W'(((64'd1 << DIV_SHIFT) + 64'd6)  / 64'd7),
    DIV_RCP_W'(((64'd1 << DIV_SHIFT) + 64'd7)  / 64'd8),
    DIV_RCP_W'(((64'd1 << DIV_SHIFT) + 64'd8)  / 64'd9),
    DIV_RCP_W'(((64'd1 << DIV_SHIFT) + 64'd9)  / 64'd10),
    DIV_RCP_W'(((64'd1 << DIV_SHIFT) + 64'd10) / 64'd11),
    DIV_RCP_W'(((64'd1 << DIV_SHIFT) + 64'd11) / 64'd12)
  };

  // Output scaling
  localparam int unsigned SH_W      = 7;
  localparam int unsigned SPOT_GAIN = 50;
  localparam int unsigned BUMP_W    = 6;

endpackage

// ===== src/gsb_pix_in_if.sv =====
// gsb_pix_in_if: valid/ready channel carrying one input pixel beat.
// Depends on gsb_pkg for field widths.
interface gsb_pix_in_if import gsb_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [COORD_W-1:0] row;
  logic [COORD_W-1:0] col;
  logic [CHAN_W-1:0]  chan0_in;
  logic [CHAN_W-1:0]  chan1_in;
  logic [CHAN_W-1:0]  chan2_in;

  modport source (output valid, row, col, chan0_in, chan1_in, chan2_in, input ready);
  modport sink   (input valid, row, col, chan0_in, chan1_in, chan2_in, output ready);
endinterface

// ===== src/gsb_pix_out_if.sv =====
// gsb_pix_out_if: valid/ready channel carrying one brightened pixel beat.
// Depends on gsb_pkg for field widths.
interface gsb_pix_out_if import gsb_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAN_W-1:0] chan0_out;
  logic [CHAN_W-1:0] chan1_out;
  logic [CHAN_W-1:0] chan2_out;

  modport source (output valid, chan0_out, chan1_out, chan2_out, input ready);
  modport sink   (input valid, chan0_out, chan1_out, chan2_out, output ready);
endinterface

// ===== src/gaussian_spot_brighten_core.sv =====
// Pipeline: an accepted pixel beat moves through the register stages in order to the output.
// Throughput: one pixel per clock unless the full pipe is blocked; 30 register stages, the bulk
//   being eleven pairs of multiply / divide-by-k stages that evaluate the exp(-r) Taylor series.
// Stalls: each stage holds while the one after it is full and blocked; empty stages keep
//   filling, so the input takes beats while a result waits as long as any stage is empty.
// Reset (rst_ni low, async): all stage valid bits and the three config registers clear to 0.
// Depends on gsb_pkg, gsb_pix_in_if, gsb_pix_out_if.
module gaussian_spot_brighten_core import gsb_pkg::*; #(
  parameter int unsigned EXP_FRAC_BITS = EXP_FRAC_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // APB-style config port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  // pixel channels
  gsb_pix_in_if.sink         pix_i,
  gsb_pix_out_if.source      pix_o
);

  localparam int unsigned E_W     = EXP_FRAC_BITS + 1;   // exp(-x) in Q1.EXP_FRAC_BITS, <= 1.0
  localparam int unsigned PROD_W  = E_W + BUMP_W;
  localparam int unsigned N_TERMS = TAYLOR_TERMS - 1;    // k = 2..12; k = 1 folds into reduction

  // stage map
  localparam int ST_DIFF = 0;
  localparam int ST_SQ   = 1;
  localparam int ST_D2   = 2;
  localparam int ST_X    = 3;
  localparam int ST_QEST = 4;
  localparam int ST_RED  = 5;
  localparam int ST_TERM = 6;
  localparam int ST_POW  = ST_TERM + 2 * N_TERMS;
  localparam int ST_OUT  = ST_POW + 1;
  localparam int NS      = ST_OUT + 1;

  localparam logic signed [E_ACC_W-1:0] E_ONE = E_ACC_W'(64'd1 << Q_FRAC);

  typedef logic [NCHAN-1:0][CHAN_W-1:0] chans_t;

  typedef struct packed {
    chans_t                   chan;
    logic signed [DIFF_W-1:0] dr;
    logic signed [DIFF_W-1:0] dc;
  } diff_t;

  typedef struct packed {
    chans_t          chan;
    logic [SQ_W-1:0] sqr;
    logic [SQ_W-1:0] sqc;
  } sq_t;

  typedef struct packed {
    chans_t          chan;
    logic [D2_W-1:0] d2;
  } d2_t;

  typedef struct packed {
    chans_t         chan;
    logic [X_W-1:0] x;
  } x_t;

  typedef struct packed {
    chans_t          chan;
    logic            far;
    logic [XR_W-1:0] xr;
    logic [N_W-1:0]  q;
  } qest_t;

  // shared by range reduction and every Taylor stage
  typedef struct packed {
    chans_t                    chan;
    logic                      far;
    logic [N_W-1:0]            n;
    logic [T_W-1:0]            r30;
    logic [T_W-1:0]            t;
    logic signed [E_ACC_W-1:0] e;
  } term_t;

  typedef struct packed {
    chans_t         chan;
    logic [E_W-1:0] e_pow;
  } pow_t;

  // ---------------------------------------------------------------------------
  // Config registers
  // ---------------------------------------------------------------------------
  logic signed [CROW_W-1:0] centre_row_q;
  logic [CCOL_W-1:0]        centre_col_q;
  logic [FALL_W-1:0]        falloff_q;
  logic                     cfg_wr;
  logic [REG_IDX_W-1:0]     reg_idx;

  assign cfg_wr  = psel && penable && pwrite;
  assign reg_idx = paddr[PADDR_W-1:2];
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      centre_row_q <= '0;
      centre_col_q <= '0;
      falloff_q    <= '0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_CENTRE_ROW: centre_row_q <= pwdata[CROW_W-1:0];
        REG_CENTRE_COL: centre_col_q <= pwdata[CCOL_W-1:0];
        REG_FALLOFF:    falloff_q    <= pwdata[FALL_W-1:0];
        default: ;                          // unmapped: ignored
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_CENTRE_ROW: prdata = {{(PDATA_W-CROW_W){1'b0}}, centre_row_q};
      REG_CENTRE_COL: prdata = {{(PDATA_W-CCOL_W){1'b0}}, centre_col_q};
      REG_FALLOFF:    prdata = PDATA_W'(falloff_q);
      default:        prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Pipeline flow control
  // A stage loads when the output drains or any stage at or after it is empty,
  // which is the usual ready ripple written as independent reductions.
  // ---------------------------------------------------------------------------
  logic [NS-1:0] v_q;
  logic [NS-1:0] v_in;
  logic [NS-1:0] ld;
  logic          in_fire;
  logic          out_fire;

  always_comb begin
    for (int i = 0; i < NS; i++) begin
      ld[i] = pix_o.ready || !(&(v_q | ((NS'(1) << i) - NS'(1))));
    end
  end

  assign v_in        = {v_q[NS-2:0], pix_i.valid};
  assign pix_i.ready = ld[ST_DIFF];
  assign pix_o.valid = v_q[ST_OUT];
  assign in_fire     = pix_i.valid && pix_i.ready;
  assign out_fire    = pix_o.valid && pix_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int i = 0; i < NS; i++) begin
        if (ld[i]) v_q[i] <= v_in[i];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Datapath
  // ---------------------------------------------------------------------------
  diff_t diff_d, diff_q;
  sq_t   sq_d,   sq_q;
  d2_t   d2_d,   d2_q;
  x_t    x_d,    x_q;
  qest_t qe_d,   qe_q;
  term_t red_d,  red_q;
  term_t tm_src [N_TERMS];
  term_t tm_d   [N_TERMS];
  term_t tm_q   [N_TERMS];
  term_t td_d   [N_TERMS];
  term_t td_q   [N_TERMS];
  pow_t  pow_d,  pow_q;
  chans_t out_d, out_q;

  logic [COORD_W-1:0]          row_c, col_c;
  logic signed [2*DIFF_W-1:0]  sqr_full, sqc_full;
  logic [XR_W+RCP_W-1:0]       qprod;
  logic [XR_W-1:0]             rprod, r0, rr;
  logic [2*T_W-1:0]            mul_p [N_TERMS];
  logic [T_W+DIV_RCP_W-1:0]    div_p [N_TERMS];
  logic [E_ACC_W-2:0]          e_pos;
  logic [SH_W-1:0]             sh;
  logic [PROD_W-1:0]           gain_p;
  logic [BUMP_W-1:0]           bump;
  logic [CHAN_W:0]             csum [NCHAN];

  // stage 0: clamp coordinates, difference to the spot centre
  always_comb begin
    row_c = (32'(pix_i.row) > MAX_DIM - 1) ? COORD_W'(MAX_DIM - 1) : pix_i.row;
    col_c = (32'(pix_i.col) > MAX_DIM - 1) ? COORD_W'(MAX_DIM - 1) : pix_i.col;
    diff_d.chan = {pix_i.chan2_in, pix_i.chan1_in, pix_i.chan0_in};
    diff_d.dr   = $signed({{(DIFF_W-COORD_W){1'b0}}, row_c})
                - $signed({{(DIFF_W-CROW_W){centre_row_q[CROW_W-1]}}, centre_row_q});
    diff_d.dc   = $signed({{(DIFF_W-COORD_W){1'b0}}, col_c})
                - $signed({{(DIFF_W-CCOL_W){1'b0}}, centre_col_q});
  end

  // stage 1: squares
  always_comb begin
    sqr_full     = diff_q.dr * diff_q.dr;
    sqc_full     = diff_q.dc * diff_q.dc;
    sq_d.chan    = diff_q.chan;
    sq_d.sqr     = sqr_full[SQ_W-1:0];
    sq_d.sqc     = sqc_full[SQ_W-1:0];
  end

  // stage 2: squared distance
  always_comb begin
    d2_d.chan = sq_q.chan;
    d2_d.d2   = D2_W'(sq_q.sqr) + D2_W'(sq_q.sqc);
  end

  // stage 3: x = d2 * falloff, Q.24
  always_comb begin
    x_d.chan = d2_q.chan;
    x_d.x    = X_W'(d2_q.d2) * X_W'(falloff_q);
  end

  // stage 4: far test, quotient estimate by reciprocal of ln2 (may be one low)
  always_comb begin
    qprod     = (XR_W+RCP_W)'(x_q.x[XR_W-1:0]) * (XR_W+RCP_W)'(RCP_LN2);
    qe_d.chan = x_q.chan;
    qe_d.far  = (x_q.x >= FAR_X);
    qe_d.xr   = x_q.x[XR_W-1:0];
    qe_d.q    = qprod[RCP_SHIFT +: N_W];
  end

  // stage 5: remainder, one-step correction, first Taylor term (t1 = R)
  always_comb begin
    rprod      = XR_W'(qe_q.q) * XR_W'(LN2_Q24);
    r0         = qe_q.xr - rprod;
    red_d.chan = qe_q.chan;
    red_d.far  = qe_q.far;
    if (r0 >= XR_W'(LN2_Q24)) begin
      red_d.n = qe_q.q + N_W'(1);
      rr      = r0 - XR_W'(LN2_Q24);
    end else begin
      red_d.n = qe_q.q;
      rr      = r0;
    end
    red_d.r30 = {rr[LN2_W-1:0], {(T_W-LN2_W){1'b0}}};
    red_d.t   = red_d.r30;
    red_d.e   = E_ONE - $signed({{(E_ACC_W-T_W){1'b0}}, red_d.r30});
  end

  // Taylor terms k = 2..12: multiply by R, then exact divide by k via reciprocal
  always_comb begin
    tm_src[0] = red_q;
    for (int j = 1; j < N_TERMS; j++) begin
      tm_src[j] = td_q[j-1];
    end
    for (int j = 0; j < N_TERMS; j++) begin
      mul_p[j]   = (2*T_W)'(tm_src[j].t) * (2*T_W)'(tm_src[j].r30);
      tm_d[j]    = tm_src[j];
      tm_d[j].t  = mul_p[j][Q_FRAC +: T_W];
      div_p[j]   = (T_W+DIV_RCP_W)'(tm_q[j].t) * (T_W+DIV_RCP_W)'(DIV_RCP[j+2]);
      td_d[j]    = tm_q[j];
      td_d[j].t  = div_p[j][DIV_SHIFT +: T_W];
      // k = j + 2: odd j is an odd term, which subtracts
      if (j[0]) begin
        td_d[j].e = tm_q[j].e - $signed({{(E_ACC_W-T_W){1'b0}}, td_d[j].t});
      end else begin
        td_d[j].e = tm_q[j].e + $signed({{(E_ACC_W-T_W){1'b0}}, td_d[j].t});
      end
    end
  end

  // scale by 2^-n and drop to EXP_FRAC_BITS; far pixels get zero
  always_comb begin
    e_pos      = td_q[N_TERMS-1].e[E_ACC_W-1] ? '0 : td_q[N_TERMS-1].e[E_ACC_W-2:0];
    sh         = SH_W'(Q_FRAC - EXP_FRAC_BITS) + SH_W'(td_q[N_TERMS-1].n);
    pow_d.chan = td_q[N_TERMS-1].chan;
    pow_d.e_pow = td_q[N_TERMS-1].far ? '0 : E_W'(e_pos >> sh);
  end

  // gain, add, saturate
  always_comb begin
    gain_p = PROD_W'(pow_q.e_pow) * PROD_W'(SPOT_GAIN);
    bump   = gain_p[EXP_FRAC_BITS +: BUMP_W];
    for (int c = 0; c < NCHAN; c++) begin
      csum[c]  = {1'b0, pow_q.chan[c]} + (CHAN_W+1)'(bump);
      out_d[c] = csum[c][CHAN_W] ? CHAN_W'(CHAN_MAX) : csum[c][CHAN_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld[ST_DIFF]) diff_q <= diff_d;
    if (ld[ST_SQ])   sq_q   <= sq_d;
    if (ld[ST_D2])   d2_q   <= d2_d;
    if (ld[ST_X])    x_q    <= x_d;
    if (ld[ST_QEST]) qe_q   <= qe_d;
    if (ld[ST_RED])  red_q  <= red_d;
    for (int j = 0; j < N_TERMS; j++) begin
      if (ld[ST_TERM + 2*j])     tm_q[j] <= tm_d[j];
      if (ld[ST_TERM + 2*j + 1]) td_q[j] <= td_d[j];
    end
    if (ld[ST_POW])  pow_q  <= pow_d;
    if (ld[ST_OUT])  out_q  <= out_d;
  end

  assign pix_o.chan0_out = out_q[0];
  assign pix_o.chan1_out = out_q[1];
  assign pix_o.chan2_out = out_q[2];

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // beats in flight change only by what enters and leaves
  a_occupancy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(rst_ni) |-> ($countones(v_q) ==
      $past($countones(v_q)) + int'($past(in_fire)) - int'($past(out_fire))))
    else $error("pipeline occupancy mismatch");

  // corrected quotient stays within the near range
  a_n_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[ST_RED] && !red_q.far |-> red_q.n <= N_W'(FAR_N))
    else $error("reduced exponent out of range");

  // corrected remainder lies below ln2
  a_r_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[ST_RED] && !red_q.far |-> red_q.r30 < LN2_Q30)
    else $error("range reduction remainder not below ln2");

  // exp(-x) never exceeds one
  a_pow_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[ST_POW] |-> pow_q.e_pow <= (E_W'(1) << EXP_FRAC_BITS))
    else $error("exp result above one");

endmodule

// ===== bench/gaussian_spot_brighten_core_tb.sv =====
`timescale 1ns / 100ps
// Self-checking bench for gaussian_spot_brighten_core: random and directed pixels
// checked against an in-bench fixed-point exp(-x) predictor.
// Depends on gsb_pkg, gsb_pix_in_if, gsb_pix_out_if and the core.
module gaussian_spot_brighten_core_tb;
  import gsb_pkg::*;

  // Result latency of the core; used only for the final quiet period.
  localparam int unsigned LATENCY   = 29;
  localparam int unsigned EFB       = EXP_FRAC_BITS_DEF;
  localparam int unsigned LIMIT     = 400000;
  localparam int unsigned N_PHASES  = 8;
  localparam int unsigned PHASE_LEN = 155;
  localparam int unsigned HOLD_LEN  = 300;
  localparam int unsigned MAX_SHOWN = 10;

  // Register index with no register behind it; writes there must be dropped.
  localparam logic [REG_IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef logic [NCHAN-1:0][CHAN_W-1:0] rgb_t;

  typedef struct packed {
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    rgb_t               chan;
  } pixel_t;

  typedef struct {
    pixel_t src;
    rgb_t   rgb;
  } lit_pixel_t;

  // --------------------------------------------------------------------------
  // Scoreboard: shadow copy of the three registers, the brightening predictor
  // and the in-order queue of expected output beats.
  // --------------------------------------------------------------------------
  class spot_scoreboard;
    logic [CROW_W-1:0] crow;
    logic [CCOL_W-1:0] ccol;
    logic [FALL_W-1:0] falloff;
    lit_pixel_t        expected_pixels[$];
    int unsigned       bad_count;

    function new();
      crow      = '0;
      ccol      = '0;
      falloff   = '0;
      bad_count = 0;
    endfunction

    function void set_reg(logic [REG_IDX_W-1:0] idx, logic [PDATA_W-1:0] v);
      case (idx)
        REG_CENTRE_ROW: crow = v[CROW_W-1:0];
        REG_CENTRE_COL: ccol = v[CCOL_W-1:0];
        REG_FALLOFF:    falloff = v[FALL_W-1:0];
        default: ;
      endcase
    endfunction

    function void flag(string msg);
      if (bad_count < MAX_SHOWN)
        $display("%0t: %s", $realtime, msg);
      bad_count++;
    endfunction

    // exp(-x), x in Q.24, result in Q.EFB: range reduction by ln2, then a
    // 12-term Taylor series for exp(-r) in Q.30, then shift by n.
    function longint unsigned gauss_weight(longint unsigned x);
      longint unsigned n, r, t;
      longint          e;
      n = x / LN2_Q24;
      if (n > FAR_N)
        return 0;
      r = (x - n * LN2_Q24) << (Q_FRAC - LN2_W);
      e = 1 << Q_FRAC;
      t = 1 << Q_FRAC;
      for (int unsigned k = 1; k <= TAYLOR_TERMS; k++) begin
        t = ((t * r) >> Q_FRAC) / k;
        if (k % 2 == 1)
          e = e - t;
        else
          e = e + t;
      end
      if (e < 0)
        e = 0;
      return e >> (Q_FRAC - EFB + n);
    endfunction

    function rgb_t brighten(pixel_t p);
      longint          dr, dc;
      longint unsigned d2, x, bump, s;
      rgb_t            q;
      // 10-bit coordinates never exceed MAX_DIM-1, so the clamp is a no-op.
      dr   = longint'(p.row) - longint'($signed(crow));
      dc   = longint'(p.col) - longint'(ccol);
      d2   = dr * dr + dc * dc;
      x    = d2 * falloff;
      bump = (SPOT_GAIN * gauss_weight(x)) >> EFB;
      for (int j = 0; j < NCHAN; j++) begin
        s    = p.chan[j] + bump;
        q[j] = (s > CHAN_MAX) ? CHAN_W'(CHAN_MAX) : CHAN_W'(s);
      end
      return q;
    endfunction

    function void note_pixel(pixel_t p);
      lit_pixel_t e;
      e.src = p;
      e.rgb = brighten(p);
      expected_pixels.push_back(e);
    endfunction

    function void check_pixel(rgb_t got);
      lit_pixel_t e;
      if (expected_pixels.size() == 0) begin
        flag($sformatf("output beat %0d/%0d/%0d with nothing expected",
                       got[0], got[1], got[2]));
        return;
      end
      e = expected_pixels.pop_front();
      for (int j = 0; j < NCHAN; j++)
        if (got[j] !== e.rgb[j])
          flag($sformatf("pixel (%0d,%0d) in %0d: chan%0d expected %0d got %0d",
                         e.src.row, e.src.col, e.src.chan[j], j, e.rgb[j], got[j]));
    endfunction

    function void check_reg(logic [REG_IDX_W-1:0] idx, logic [PDATA_W-1:0] got);
      logic [PDATA_W-1:0] want, mask;
      case (idx)
        REG_CENTRE_ROW: begin
          want = PDATA_W'(crow);
          mask = PDATA_W'((64'd1 << CROW_W) - 1);
        end
        REG_CENTRE_COL: begin
          want = PDATA_W'(ccol);
          mask = PDATA_W'((64'd1 << CCOL_W) - 1);
        end
        default: begin
          want = PDATA_W'(falloff);
          mask = '1;
        end
      endcase
      if ((got & mask) !== want)
        flag($sformatf("register %0d readback expected 0x%0h got 0x%0h", idx, want, got & mask));
    endfunction

    function int unsigned pending();
      return expected_pixels.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset, config port and the two pixel channels
  // --------------------------------------------------------------------------
  logic               clk_i;
  logic               rst_ni;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  gsb_pix_in_if  in_bus ();
  gsb_pix_out_if out_bus ();

  spot_scoreboard board = new();

  // Idle knobs, changed per phase by the main sequence.
  int unsigned idle_pct;    // chance the source leaves a gap after a beat
  int unsigned stall_pct;   // chance the sink drops ready in a cycle
  int unsigned hold_len;    // request for one long sink hold-off
  int unsigned cycles;

  gaussian_spot_brighten_core uut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .pix_i   (in_bus),
    .pix_o   (out_bus)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Watchdog: sized from the slowest legal run (both sides idling, one long
  // hold-off per pressure phase) and then taken several times over.
  initial begin
    cycles = 0;
    while (cycles < LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  // Sink side. ready changes on the falling edge only. A hold-off request is
  // picked up here and counted down in this process while the source keeps
  // offering beats, so the pipe fills and back-pressures its input.
  initial begin
    int unsigned hold_left;
    hold_left     = 0;
    out_bus.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_len > 0) begin
        hold_left = hold_len;
        hold_len  = 0;
      end
      if (hold_left > 0) begin
        out_bus.ready <= 1'b0;
        hold_left--;
      end else begin
        out_bus.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Output monitor: every beat that crosses the sink handshake is checked
  // against the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && out_bus.valid && out_bus.ready)
      board.check_pixel({out_bus.chan2_out, out_bus.chan1_out, out_bus.chan0_out});
  end

  // --------------------------------------------------------------------------
  // Drivers. All of them are entered and left on a falling edge.
  // --------------------------------------------------------------------------

  // One APB transfer: setup cycle, then access cycle until pready. The shadow
  // register is updated at the same edge the core takes the write.
  task automatic apb_xfer(input logic [REG_IDX_W-1:0] idx, input bit wr,
                          input logic [PDATA_W-1:0] wdata,
                          output logic [PDATA_W-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= PADDR_W'({idx, 2'b00});
    pwdata  <= wdata;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    if (wr)
      board.set_reg(idx, wdata);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Holds until every expected beat has come out, plus a short margin.
  task automatic wait_drained();
    while (board.pending() != 0)
      @(posedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // Registers change only with the pipe empty and the source idle. Also pokes
  // the unmapped index and reads all three back.
  task automatic configure(input logic [PDATA_W-1:0] cr, cc, fo);
    logic [PDATA_W-1:0] rd;
    in_bus.valid <= 1'b0;
    wait_drained();
    apb_xfer(REG_CENTRE_ROW, 1'b1, cr, rd);
    apb_xfer(REG_CENTRE_COL, 1'b1, cc, rd);
    apb_xfer(REG_FALLOFF, 1'b1, fo, rd);
    apb_xfer(REG_UNUSED, 1'b1, $urandom, rd);
    apb_xfer(REG_CENTRE_ROW, 1'b0, '0, rd);
    board.check_reg(REG_CENTRE_ROW, rd);
    apb_xfer(REG_CENTRE_COL, 1'b0, '0, rd);
    board.check_reg(REG_CENTRE_COL, rd);
    apb_xfer(REG_FALLOFF, 1'b0, '0, rd);
    board.check_reg(REG_FALLOFF, rd);
  endtask

  // Offers one beat and waits for the handshake, then drops valid for a random idle_pct gap;
  // with no gap, valid stays high on exit so back-to-back beats need no extra edge.
  task automatic send_pixel(input pixel_t p);
    in_bus.valid    <= 1'b1;
    in_bus.row      <= p.row;
    in_bus.col      <= p.col;
    in_bus.chan0_in <= p.chan[0];
    in_bus.chan1_in <= p.chan[1];
    in_bus.chan2_in <= p.chan[2];
    do @(posedge clk_i); while (!in_bus.ready);
    board.note_pixel(p);
    @(negedge clk_i);
    while ($urandom_range(99) < idle_pct) begin
      in_bus.valid <= 1'b0;
      @(negedge clk_i);
    end
  endtask

  function automatic pixel_t mk(int unsigned r, c, c0, c1, c2);
    pixel_t p;
    p.row     = COORD_W'(r);
    p.col     = COORD_W'(c);
    p.chan[0] = CHAN_W'(c0);
    p.chan[1] = CHAN_W'(c1);
    p.chan[2] = CHAN_W'(c2);
    return p;
  endfunction

  // Half the pixels land anywhere (mostly far, exp term zero), half within
  // 40 px of the centre where the exp term is live. Channels lean toward the
  // saturation knee and toward zero.
  function automatic pixel_t rand_pixel();
    pixel_t p;
    int     r, c;
    if ($urandom_range(1) == 0) begin
      p.row = COORD_W'($urandom);
      p.col = COORD_W'($urandom);
    end else begin
      r = int'($signed(board.crow)) + int'($urandom_range(80)) - 40;
      c = int'(board.ccol) + int'($urandom_range(80)) - 40;
      p.row = (r < 0) ? '0 : (r > MAX_DIM - 1) ? COORD_W'(MAX_DIM - 1) : COORD_W'(r);
      p.col = (c < 0) ? '0 : (c > MAX_DIM - 1) ? COORD_W'(MAX_DIM - 1) : COORD_W'(c);
    end
    for (int j = 0; j < NCHAN; j++) begin
      case ($urandom_range(3))
        1:       p.chan[j] = CHAN_W'(CHAN_MAX - $urandom_range(60));
        2:       p.chan[j] = CHAN_W'($urandom_range(8));
        default: p.chan[j] = CHAN_W'($urandom);
      endcase
    end
    return p;
  endfunction

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_ni          = 1'b0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    in_bus.valid    = 1'b0;
    in_bus.row      = '0;
    in_bus.col      = '0;
    in_bus.chan0_in = '0;
    in_bus.chan1_in = '0;
    in_bus.chan2_in = '0;
    idle_pct        = 0;
    stall_pct       = 0;
    hold_len        = 0;

    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Registers at reset: zero falloff, so every channel gets the full +50;
    // corners of the image and channel values around the saturation knee.
    send_pixel(mk(0, 0, 0, 0, 0));
    send_pixel(mk(1023, 1023, 255, 255, 255));
    send_pixel(mk(0, 1023, 205, 206, 204));
    send_pixel(mk(1023, 0, 8'hAA, 8'h55, 1));

    // Unit falloff at the origin: x equals d2, so exp(-0), exp(-1), exp(-2),
    // exp(-25), exp(-36) and one well past the far cut-off.
    configure(32'h0, 32'h0, 32'h0100_0000);
    send_pixel(mk(0, 0, 100, 205, 255));
    send_pixel(mk(0, 1, 0, 236, 250));
    send_pixel(mk(1, 1, 10, 20, 30));
    send_pixel(mk(3, 4, 200, 128, 7));
    send_pixel(mk(6, 0, 255, 0, 1));
    send_pixel(mk(30, 0, 17, 34, 51));

    // Most negative row, largest column, largest falloff: everything is far.
    configure(32'hFFFF_FC00, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_pixel(mk(0, 1023, 0, 255, 128));
    send_pixel(mk(1023, 0, 255, 0, 128));

    // Largest positive row with the smallest nonzero falloff: small x over
    // the whole image.
    configure(32'h3FF, 32'h3FF, 32'h1);
    send_pixel(mk(1023, 1023, 1, 2, 3));
    send_pixel(mk(0, 0, 254, 210, 0));
    send_pixel(mk(512, 700, 99, 180, 240));

    // Random phases, rotating through the idle patterns; two of them start
    // with a long sink hold-off while the source keeps pushing.
    for (int unsigned ph = 0; ph < N_PHASES; ph++) begin
      case (ph)
        1:       configure(32'h3FF, 32'h0, 32'hFFFF_FFFF);
        4:       configure(32'h0, 32'h0, 32'h0);
        6:       configure(32'h400, 32'hFFF, 32'h1);
        default: configure(($urandom_range(3) == 0) ? $urandom
                             : PDATA_W'(-int'($urandom_range(1024))),
                           ($urandom_range(3) == 0) ? $urandom
                             : PDATA_W'($urandom_range(2048)),
                           $urandom >> $urandom_range(31));
      endcase
      case (ph % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 62; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 62; end
        default: begin idle_pct = 26; stall_pct = 26; end
      endcase
      if (ph == 0 || ph == 5)
        hold_len = HOLD_LEN;
      for (int unsigned i = 0; i < PHASE_LEN; i++)
        send_pixel(rand_pixel());
      in_bus.valid <= 1'b0;
    end

    wait_drained();
    repeat (LATENCY + 8) @(negedge clk_i);

    if (board.bad_count == 0 && board.pending() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
